>>> rtl/teq_pkg.sv
// Package for the timed event queue: op and result codes, entry and state types.
// No dependencies.
package teq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned IdW   = 16;
  localparam int unsigned ValW  = 32;
  localparam int unsigned MaxRes = 32;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_SERVICE = 3'd1,
    OP_CANCEL_CALLER = 3'd2,
    OP_CANCEL_TARGET = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [TimeW-1:0] due;
    logic [IdW-1:0]   target;
    logic [IdW-1:0]   input_name;
    logic [IdW-1:0]   caller;
    logic [IdW-1:0]   activator;
    logic [ValW-1:0]  value;
    logic [IdW-1:0]   stamp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INSERT = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

endpackage

>>> rtl/timed_event_priority_queue.sv
// Top level of the timed event queue: sequencer over one entry memory and one comparator.
// Depends on teq_pkg and teq_store.
// Service, cancel and query walk every occupied entry, one per cycle; an insert walks down
// from the tail to its position, and an insert into a full queue is refused without a walk.
// Fired events stream one per cycle during the walk; the final result is in the last busy cycle.
// A new operation is accepted only while busy is low; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the queue; entry contents are not cleared.
module timed_event_priority_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_now,
  input  logic [23:0] in_delay,
  input  logic [15:0] in_target_id,
  input  logic [15:0] in_input_id,
  input  logic [15:0] in_caller_id,
  input  logic [15:0] in_activator_id,
  input  logic [31:0] in_value,
  input  logic [15:0] in_output_id,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic        out_ok,
  output logic [15:0] out_fired_target,
  output logic [15:0] out_fired_input,
  output logic [15:0] out_fired_caller,
  output logic [15:0] out_fired_activator,
  output logic [31:0] out_fired_value,
  output logic [15:0] out_fired_output,
  output logic [5:0]  out_removed_count,
  output logic        out_last
);
  import teq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);

  state_t        state_r, state_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] idx_r, idx_nxt;   // scan: entry in rdata; insert: slot above rdata entry
  logic [OW-1:0] wr_r, wr_nxt;     // compaction write pointer
  logic [6:0]    cnt_r, cnt_nxt;   // removed or fired entries
  logic          found_r, found_nxt;
  logic          pend_r, pend_nxt;
  entry_t        pend_ent_r, pend_ent_nxt;
  op_t           op_r;
  logic [31:0]   now_r;
  entry_t        new_r;

  entry_t        rdata, wdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          hit;
  logic          accept;
  logic          op_known;

  logic          res_emit;
  kind_t         res_kind;
  logic          res_ok, res_last;
  entry_t        res_ent;
  logic [5:0]    res_rem;

  logic          out_valid_r;
  kind_t         out_kind_r;
  logic          out_ok_r, out_last_r;
  entry_t        out_ent_r;
  logic [5:0]    out_rem_r;

  logic [32:0] due_sum;
  logic [31:0] due_sat;

  assign due_sum = {1'b0, in_now} + {9'd0, in_delay};
  assign due_sat = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];

  assign accept   = start && (state_r == ST_IDLE);
  assign op_known = (in_op <= 3'(OP_QUERY));

  teq_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // shared comparator; entries due for service form a prefix of the sorted list
  always_comb begin
    unique case (op_r) inside
      OP_SERVICE: hit = (rdata.due <= now_r) && (cnt_r < 7'(MaxRes));
      OP_CANCEL_CALLER: hit = (new_r.caller != '0) && (rdata.caller == new_r.caller);
      OP_CANCEL_TARGET, OP_QUERY:
        hit = (new_r.target != '0) && (rdata.target == new_r.target) &&
              ((new_r.input_name == '0) || (rdata.input_name == new_r.input_name));
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    idx_nxt      = idx_r;
    wr_nxt       = wr_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    pend_nxt     = pend_r;
    pend_ent_nxt = pend_ent_r;
    we           = 1'b0;
    waddr        = wr_r[AW-1:0];
    wdata        = rdata;
    raddr        = idx_r[AW-1:0];
    res_emit     = 1'b0;
    res_kind     = KIND_INSERT;
    res_ok       = 1'b0;
    res_last     = 1'b1;
    res_ent      = '0;
    res_rem      = '0;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt   = '0;
        wr_nxt    = '0;
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        pend_nxt  = 1'b0;
        raddr     = '0;
        if (accept && op_known) begin
          if (in_op == 3'(OP_INSERT)) begin
            if (occ_r == OW'(DEPTH)) begin
              state_nxt = ST_DONE;
              res_emit  = 1'b1;
            end else begin
              // walk down from the tail, shifting later entries up by one
              state_nxt = ST_INSERT;
              idx_nxt   = occ_r;
              raddr     = AW'(occ_r - OW'(1));
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_INSERT: begin
        we    = 1'b1;
        waddr = idx_r[AW-1:0];
        raddr = AW'(idx_r - OW'(2));
        if ((idx_r == '0) || (rdata.due <= new_r.due)) begin
          wdata     = new_r;
          occ_nxt   = occ_r + OW'(1);
          state_nxt = ST_DONE;
          res_emit  = 1'b1;
          res_ok    = 1'b1;
        end else begin
          wdata   = rdata;
          idx_nxt = idx_r - OW'(1);
        end
      end
      ST_SCAN: begin
        raddr = AW'(idx_r + OW'(1));
        if (idx_r < occ_r) begin
          idx_nxt = idx_r + OW'(1);
          if (op_r == OP_QUERY) begin
            if (hit) found_nxt = 1'b1;
          end else if (hit) begin
            cnt_nxt = cnt_r + 7'd1;
            if (op_r == OP_SERVICE) begin
              // held one entry back so the final one can be marked
              pend_nxt     = 1'b1;
              pend_ent_nxt = rdata;
              if (pend_r) begin
                res_emit = 1'b1;
                res_kind = KIND_FIRED;
                res_ok   = 1'b1;
                res_last = 1'b0;
                res_ent  = pend_ent_r;
              end
            end
          end else begin
            we     = 1'b1;
            waddr  = wr_r[AW-1:0];
            wdata  = rdata;
            wr_nxt = wr_r + OW'(1);
          end
        end else begin
          state_nxt = ST_DONE;
          res_emit  = 1'b1;
          if (op_r != OP_QUERY) occ_nxt = wr_r;
          unique case (op_r) inside
            OP_SERVICE: begin
              res_kind = KIND_FIRED;
              res_ok   = pend_r;
              if (pend_r) res_ent = pend_ent_r;
            end
            OP_CANCEL_CALLER, OP_CANCEL_TARGET: begin
              res_kind = KIND_CANCEL;
              res_ok   = 1'b1;
              res_rem  = (cnt_r > 7'd63) ? 6'd63 : cnt_r[5:0];
            end
            default: begin
              res_kind = KIND_QUERY;
              res_ok   = found_r;
            end
          endcase
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= res_emit;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    wr_r       <= wr_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    pend_r     <= pend_nxt;
    pend_ent_r <= pend_ent_nxt;
    out_kind_r <= res_kind;
    out_ok_r   <= res_ok;
    out_last_r <= res_last;
    out_ent_r  <= res_ent;
    out_rem_r  <= res_rem;
    if (accept && op_known) begin
      op_r  <= op_t'(in_op);
      now_r <= in_now;
      new_r <= '{due: due_sat, target: in_target_id, input_name: in_input_id,
                 caller: in_caller_id, activator: in_activator_id,
                 value: in_value, stamp: in_output_id};
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_ok              = out_ok_r;
  assign out_fired_target    = out_ent_r.target;
  assign out_fired_input     = out_ent_r.input_name;
  assign out_fired_caller    = out_ent_r.caller;
  assign out_fired_activator = out_ent_r.activator;
  assign out_fired_value     = out_ent_r.value;
  assign out_fired_output    = out_ent_r.stamp;
  assign out_removed_count   = out_rem_r;
  assign out_last            = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n) occ_r <= OW'(DEPTH))
    else $error("occupancy above depth");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("result while idle");
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != KIND_FIRED)) |-> out_last)
    else $error("single result not marked last");

endmodule

>>> rtl/teq_store.sv
// Entry memory of the timed event queue: one write port, one registered read port.
// Depends on teq_pkg.
module teq_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  teq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output teq_pkg::entry_t rdata
);
  import teq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
